// File: hdl/wnpp_pkg.sv
// Shared types and constants for the windowed nearest path point search.
package wnpp_pkg;

  localparam int PATH_DEPTH_DEF  = 4096;
  localparam int COORD_WIDTH_DEF = 24;

  localparam int ADDR_W  = 12;
  localparam int LEN_W   = 13;
  localparam int WIN_W   = 8;
  localparam int IDX_W   = 13;
  localparam int OUT_D_W = 49;
  localparam int CFG_IDX_W = 2;

  localparam logic [WIN_W-1:0] BACK_WINDOW_RST  = 8'd10;
  localparam logic [WIN_W-1:0] AHEAD_WINDOW_RST = 8'd120;
  localparam logic [OUT_D_W-1:0] DIST_MAX = '1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PATH_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AHEAD_WINDOW = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

endpackage

// File: hdl/wnpp_ram.sv
// Generic single-port RAM with registered read.
module wnpp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: hdl/wnpp_dist.sv
// Pipelined squared-distance unit shared by every point of a scan.
module wnpp_dist #(
  parameter int COORD_WIDTH = wnpp_pkg::COORD_WIDTH_DEF,
  localparam int SW = 2 * COORD_WIDTH + 1,
  localparam int KW = (SW > 64) ? 64 : SW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wnpp_pkg::scan_tag_t           issue,
  input  logic [COORD_WIDTH-1:0]        rd_x,
  input  logic [COORD_WIDTH-1:0]        rd_y,
  input  logic signed [COORD_WIDTH-1:0] qx,
  input  logic signed [COORD_WIDTH-1:0] qy,
  output wnpp_pkg::scan_tag_t           res_tag,
  output logic [KW-1:0]                 dsq,
  output logic                          busy
);

  wnpp_pkg::scan_tag_t t1, t2, t3, t4;

  logic signed [COORD_WIDTH:0] dx_c, dy_c;
  logic [COORD_WIDTH-1:0]      mx_c, my_c, mx, my;
  logic [2*COORD_WIDTH-1:0]    sqx, sqy;
  logic [SW-1:0]               sum_c;

  assign dx_c = (COORD_WIDTH+1)'($signed(rd_x)) - (COORD_WIDTH+1)'(qx);
  assign dy_c = (COORD_WIDTH+1)'($signed(rd_y)) - (COORD_WIDTH+1)'(qy);
  assign mx_c = dx_c[COORD_WIDTH] ? COORD_WIDTH'(-dx_c) : COORD_WIDTH'(dx_c);
  assign my_c = dy_c[COORD_WIDTH] ? COORD_WIDTH'(-dy_c) : COORD_WIDTH'(dy_c);
  assign sum_c = SW'(sqx) + SW'(sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.vld <= 1'b0;
      t2.vld <= 1'b0;
      t3.vld <= 1'b0;
      t4.vld <= 1'b0;
    end else begin
      t1.vld <= issue.vld;
      t2.vld <= t1.vld;
      t3.vld <= t2.vld;
      t4.vld <= t3.vld;
    end
    t1.idx <= issue.idx;
    t2.idx <= t1.idx;
    t3.idx <= t2.idx;
    t4.idx <= t3.idx;
    mx  <= mx_c;
    my  <= my_c;
    sqx <= mx * mx;
    sqy <= my * my;
  end

  // sum of squares saturates at 64 bits for the compare when it is wider
  generate
    if (SW > 64) begin : g_sat
      always_ff @(posedge clk) begin
        dsq <= (|sum_c[SW-1:64]) ? '1 : sum_c[63:0];
      end
    end else begin : g_nosat
      always_ff @(posedge clk) begin
        dsq <= sum_c;
      end
    end
  endgenerate

  assign res_tag = t4;
  assign busy    = t1.vld | t2.vld | t3.vld | t4.vld;

endmodule

// File: hdl/windowed_nearest_path_point.sv
// Top level: path store, scan sequencer and best-match tracking.
//
// Input channel (in_valid/in_ready) carries one item: a load writes one x,y
// point into slot point_address and gives no result; a query scans the
// clipped window [start_index - back_window, start_index + ahead_window)
// bounded by 0 and path_length (at most PATH_DEPTH), and gives one result item.
// A query reads one point per cycle from the single-port path memory,
// then the distance pipeline drains and out_valid rises; the next item
// can be taken in the same cycle that out_valid rises.
// in_ready is low while a query runs. The result sits in an output
// register; loads are taken while it waits. A second query finishes its
// scan and then holds until the receiver takes the earlier result.
// Configuration (cfg_valid/cfg_ready, always ready) writes path_length,
// back_window, ahead_window by index; write only while idle.
// Reset (rst, synchronous) empties the pipeline, drops out_valid and
// loads path_length 0, back_window 10, ahead_window 120. The path memory
// is not cleared; a query must only cover loaded slots.
// An empty window returns start_index, distance 0, window_empty set.
module windowed_nearest_path_point #(
  parameter int PATH_DEPTH  = wnpp_pkg::PATH_DEPTH_DEF,
  parameter int COORD_WIDTH = wnpp_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             operation,
  input  logic [wnpp_pkg::ADDR_W-1:0]      point_address,
  input  logic signed [COORD_WIDTH-1:0]    coord_x,
  input  logic signed [COORD_WIDTH-1:0]    coord_y,
  input  logic [wnpp_pkg::ADDR_W-1:0]      start_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [wnpp_pkg::ADDR_W-1:0]      nearest_index,
  output logic [wnpp_pkg::OUT_D_W-1:0]     min_distance_sq,
  output logic                             window_empty,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wnpp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wnpp_pkg::LEN_W-1:0]       cfg_data
);

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int SW = 2 * COORD_WIDTH + 1;
  localparam int KW = (SW > 64) ? 64 : SW;
  localparam int IW = wnpp_pkg::IDX_W;

  wnpp_pkg::state_t state, state_next;

  logic [wnpp_pkg::LEN_W-1:0] path_length;
  logic [wnpp_pkg::WIN_W-1:0] back_window, ahead_window;

  logic signed [COORD_WIDTH-1:0] qx, qy;
  logic [wnpp_pkg::ADDR_W-1:0]   sidx;
  logic [IW-1:0]                 idx, hi;
  logic [IW-1:0]                 lo_c, hi_c, lim_c, sum_c;
  logic                          found;
  logic [IW-1:0]                 best_idx;
  logic [KW-1:0]                 best_d;
  logic [wnpp_pkg::OUT_D_W-1:0]  dist_sat;

  logic          issue, load_out, accept, query_acc, we;
  logic [AW-1:0] ram_addr;
  logic [COORD_WIDTH-1:0] rd_x, rd_y;

  wnpp_pkg::scan_tag_t issue_tag, res_tag;
  logic [KW-1:0]       dsq;
  logic                busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      path_length  <= '0;
      back_window  <= wnpp_pkg::BACK_WINDOW_RST;
      ahead_window <= wnpp_pkg::AHEAD_WINDOW_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wnpp_pkg::REG_PATH_LENGTH:  path_length  <= cfg_data;
        wnpp_pkg::REG_BACK_WINDOW:  back_window  <= cfg_data[wnpp_pkg::WIN_W-1:0];
        wnpp_pkg::REG_AHEAD_WINDOW: ahead_window <= cfg_data[wnpp_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // window bounds
  always_comb begin
    lo_c  = (start_index > wnpp_pkg::ADDR_W'(back_window))
          ? IW'(start_index - wnpp_pkg::ADDR_W'(back_window)) : '0;
    lim_c = (32'(path_length) > PATH_DEPTH) ? IW'(PATH_DEPTH) : path_length;
    sum_c = IW'(start_index) + IW'(ahead_window);
    hi_c  = (sum_c > lim_c) ? lim_c : sum_c;
  end

  assign accept    = in_valid && in_ready;
  assign query_acc = accept && (operation == wnpp_pkg::OP_QUERY);
  assign we        = accept && (operation == wnpp_pkg::OP_LOAD)
                     && (32'(point_address) < PATH_DEPTH);
  assign ram_addr  = we ? AW'(point_address) : AW'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wnpp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    issue      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      wnpp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && operation == wnpp_pkg::OP_QUERY) begin
          state_next = wnpp_pkg::ST_SCAN;
        end
      end
      wnpp_pkg::ST_SCAN: begin
        if (idx < hi) begin
          issue = 1'b1;
        end else if (!busy) begin
          state_next = wnpp_pkg::ST_FINISH;
        end
      end
      wnpp_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = wnpp_pkg::ST_IDLE;
        end
      end
      default: state_next = wnpp_pkg::ST_IDLE;
    endcase
  end

  assign issue_tag.vld = issue;
  assign issue_tag.idx = idx;

  wnpp_ram #(.WIDTH(COORD_WIDTH), .DEPTH(PATH_DEPTH)) u_ram_x (
    .clk   (clk),
    .we    (we),
    .addr  (ram_addr),
    .wdata (coord_x),
    .rdata (rd_x)
  );

  wnpp_ram #(.WIDTH(COORD_WIDTH), .DEPTH(PATH_DEPTH)) u_ram_y (
    .clk   (clk),
    .we    (we),
    .addr  (ram_addr),
    .wdata (coord_y),
    .rdata (rd_y)
  );

  wnpp_dist #(.COORD_WIDTH(COORD_WIDTH)) u_dist (
    .clk     (clk),
    .rst     (rst),
    .issue   (issue_tag),
    .rd_x    (rd_x),
    .rd_y    (rd_y),
    .qx      (qx),
    .qy      (qy),
    .res_tag (res_tag),
    .dsq     (dsq),
    .busy    (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (query_acc) begin
      found <= 1'b0;
    end else if (res_tag.vld) begin
      found <= 1'b1;
    end
    if (query_acc) begin
      qx       <= coord_x;
      qy       <= coord_y;
      sidx     <= start_index;
      idx      <= lo_c;
      hi       <= hi_c;
      best_idx <= IW'(start_index);
    end else begin
      if (issue) begin
        idx <= idx + 1'b1;
      end
      // first minimum wins
      if (res_tag.vld && (!found || dsq < best_d)) begin
        best_d   <= dsq;
        best_idx <= res_tag.idx;
      end
    end
  end

  generate
    if (KW > wnpp_pkg::OUT_D_W) begin : g_osat
      assign dist_sat = (best_d > KW'(wnpp_pkg::DIST_MAX))
                      ? wnpp_pkg::DIST_MAX : best_d[wnpp_pkg::OUT_D_W-1:0];
    end else begin : g_ozx
      assign dist_sat = wnpp_pkg::OUT_D_W'(best_d);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      nearest_index   <= found ? best_idx[wnpp_pkg::ADDR_W-1:0] : sidx;
      min_distance_sq <= found ? dist_sat : '0;
      window_empty    <= !found;
    end
  end

endmodule

// File: hdl/wnpp_checker.sv
// Port-level checks for the nearest path point block, with bind.
module wnpp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           operation,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [wnpp_pkg::ADDR_W-1:0]    nearest_index,
  input logic [wnpp_pkg::OUT_D_W-1:0]   min_distance_sq,
  input logic                           window_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(nearest_index)
      && $stable(min_distance_sq) && $stable(window_empty))
    else $error("result item changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_empty |-> min_distance_sq == '0)
    else $error("empty window with nonzero distance");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == wnpp_pkg::OP_QUERY |=> !in_ready)
    else $error("item taken while query runs");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind windowed_nearest_path_point wnpp_checker u_wnpp_checker (.*);
